>>> hdl/light_level_halving_search_assert.svh
// assertion macros for the light level search back part
`ifndef LIGHT_LEVEL_HALVING_SEARCH_ASSERT_SVH
`define LIGHT_LEVEL_HALVING_SEARCH_ASSERT_SVH

// condition that must hold at every clock edge out of reset
`define LLHS_ASSERT_ALWAYS(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// condition in one cycle that implies another in the next cycle
`define LLHS_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> hdl/llhs_pkg.sv
// shared types, codes and helpers for the light level halving search
package llhs_pkg;

    localparam int DRIVE_BITS     = 10;
    localparam int LEVEL_BITS     = 12;
    localparam int FRAC_BITS      = 4;
    localparam int AVG_BITS       = 16;
    localparam int VALUE_BITS     = 10;
    localparam int ERR_BITS       = 17;
    localparam int CHANNELS       = 3;
    localparam int CODE_BITS      = 2;
    localparam int SEQ_CODES      = 4;
    localparam int SEQ_BITS       = CODE_BITS * SEQ_CODES;
    localparam int LEN_BITS       = 3;
    localparam int KIND_BITS      = 2;
    localparam int VERDICT_BITS   = 2;
    localparam int DEFAULT_SEQUENCE_SLOTS = 4;

    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = CHANNELS * LEVEL_BITS;
    localparam int PACKED_DRIVE_BITS = CHANNELS * DRIVE_BITS;
    localparam int PACKED_LEVEL_BITS = CHANNELS * LEVEL_BITS;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_COLOR_SEQUENCE   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SEQUENCE_LENGTH  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_DRIVE        = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INITIAL_DRIVE    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TARGET_LEVELS    = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TOLERANCE_LEVELS = 3'd5;

    localparam logic [PACKED_DRIVE_BITS-1:0] MAX_DRIVE_RESET = '1;
    localparam logic [PACKED_LEVEL_BITS-1:0] TARGET_RESET    = 36'd3524075730;
    localparam logic [PACKED_LEVEL_BITS-1:0] TOLERANCE_RESET = 36'd167813130;

    // input operation codes
    localparam logic OP_START   = 1'b0;
    localparam logic OP_MEASURE = 1'b1;

    // channel code that keeps the previous channel
    localparam logic [CODE_BITS-1:0] CODE_KEEP   = 2'd3;
    localparam logic [CODE_BITS-1:0] SELECT_BASE = 2'd3;

    // result kinds and verdicts
    localparam logic [KIND_BITS-1:0] KIND_MASK    = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_SELECT  = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_DRIVE   = 2'd2;
    localparam logic [KIND_BITS-1:0] KIND_VERDICT = 2'd3;

    localparam logic [VERDICT_BITS-1:0] VERDICT_PASS       = 2'd0;
    localparam logic [VERDICT_BITS-1:0] VERDICT_TOLERANCE  = 2'd1;
    localparam logic [VERDICT_BITS-1:0] VERDICT_NO_CHANNEL = 2'd2;

    // commands from front to back
    typedef logic [2:0] cmd_op_t;
    localparam cmd_op_t CMD_EMPTY = 3'd0;
    localparam cmd_op_t CMD_START = 3'd1;
    localparam cmd_op_t CMD_DRIVE = 3'd2;
    localparam cmd_op_t CMD_FAIL  = 3'd3;
    localparam cmd_op_t CMD_NEXT  = 3'd4;
    localparam cmd_op_t CMD_PASS  = 3'd5;

    typedef struct packed {
        cmd_op_t                op;
        logic [CHANNELS-1:0]    mask;
        logic [CODE_BITS-1:0]   channel;
        logic [DRIVE_BITS-1:0]  drive;
        logic [DRIVE_BITS-1:0]  best;
    } cmd_t;

    typedef struct packed {
        logic [SEQ_BITS-1:0]          color_sequence;
        logic [LEN_BITS-1:0]          sequence_length;
        logic [PACKED_DRIVE_BITS-1:0] max_drive;
        logic [PACKED_DRIVE_BITS-1:0] initial_drive;
        logic [PACKED_LEVEL_BITS-1:0] target;
        logic [PACKED_LEVEL_BITS-1:0] tolerance;
    } cfg_t;

    // channel three wraps to red
    function automatic logic [DRIVE_BITS-1:0] channel_drive(
        input logic [PACKED_DRIVE_BITS-1:0] packed_val,
        input logic [CODE_BITS-1:0]         ch
    );
        logic [DRIVE_BITS-1:0] d;
        case (ch)
            2'd1:    d = packed_val[DRIVE_BITS +: DRIVE_BITS];
            2'd2:    d = packed_val[2*DRIVE_BITS +: DRIVE_BITS];
            default: d = packed_val[0 +: DRIVE_BITS];
        endcase
        return d;
    endfunction

    function automatic logic [LEVEL_BITS-1:0] channel_level(
        input logic [PACKED_LEVEL_BITS-1:0] packed_val,
        input logic [CODE_BITS-1:0]         ch
    );
        logic [LEVEL_BITS-1:0] l;
        case (ch)
            2'd1:    l = packed_val[LEVEL_BITS +: LEVEL_BITS];
            2'd2:    l = packed_val[2*LEVEL_BITS +: LEVEL_BITS];
            default: l = packed_val[0 +: LEVEL_BITS];
        endcase
        return l;
    endfunction

    // slots past the stored codes read as red
    function automatic logic [CODE_BITS-1:0] slot_code(
        input logic [SEQ_BITS-1:0] seq,
        input int                  slot
    );
        logic [CODE_BITS-1:0] c;
        c = '0;
        for (int k = 0; k < SEQ_CODES; k++) begin
            if (slot == k) c = seq[CODE_BITS*k +: CODE_BITS];
        end
        return c;
    endfunction

endpackage

>>> hdl/light_level_halving_search.sv
// top level of the light level halving search with its configuration registers
//
// Input items are taken at one per cycle as long as the four-entry command
// queue has room; the front part updates the search state for each item in
// the cycle it is taken. The back part sends one result transfer per cycle,
// so the rate is set by the result count of each item: a start gives up to
// nine results (mask, two per enabled channel, then select and maximum drive
// of the first channel), a measurement gives one drive, or at the end of a
// channel the best drive plus a verdict or plus the next channel's select and
// drive. A result waiting on m_tready does not hold up the input side until
// the queue is full. Configuration writes take effect on the next cycle.
module light_level_halving_search #(
    parameter int SEQUENCE_SLOTS = llhs_pkg::DEFAULT_SEQUENCE_SLOTS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [15:0]                         s_tdata,     // [15:0] measured_average
    input  logic [0:0]                          s_tuser,     // [0] operation
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [15:0]                         m_tdata,     // [9:0] value, [11:10] verdict
    output logic [1:0]                          m_tuser,     // [1:0] kind
    output logic                                m_tlast,
    input  logic                                cfg_wr_en,
    input  logic [llhs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [llhs_pkg::CFG_DATA_BITS-1:0]  cfg_wr_data
);
    import llhs_pkg::*;

    cfg_t                  cfg_reg;
    logic                  push;
    cmd_t                  push_cmd;
    logic                  queue_full;
    logic                  queue_empty;
    logic                  pop;
    cmd_t                  head_cmd;
    logic [KIND_BITS-1:0]    out_kind;
    logic [VALUE_BITS-1:0]   out_value;
    logic [VERDICT_BITS-1:0] out_verdict;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.color_sequence  <= '0;
            cfg_reg.sequence_length <= '0;
            cfg_reg.max_drive       <= MAX_DRIVE_RESET;
            cfg_reg.initial_drive   <= '0;
            cfg_reg.target          <= TARGET_RESET;
            cfg_reg.tolerance       <= TOLERANCE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_COLOR_SEQUENCE:   cfg_reg.color_sequence  <= cfg_wr_data[SEQ_BITS-1:0];
                CFG_SEQUENCE_LENGTH:  cfg_reg.sequence_length <= cfg_wr_data[LEN_BITS-1:0];
                CFG_MAX_DRIVE:        cfg_reg.max_drive <= cfg_wr_data[PACKED_DRIVE_BITS-1:0];
                CFG_INITIAL_DRIVE:    cfg_reg.initial_drive <= cfg_wr_data[PACKED_DRIVE_BITS-1:0];
                CFG_TARGET_LEVELS:    cfg_reg.target    <= cfg_wr_data[PACKED_LEVEL_BITS-1:0];
                CFG_TOLERANCE_LEVELS: cfg_reg.tolerance <= cfg_wr_data[PACKED_LEVEL_BITS-1:0];
                default: ;
            endcase
        end
    end

    llhs_front #(
        .SEQUENCE_SLOTS(SEQUENCE_SLOTS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .in_operation(s_tuser[0]),
        .in_average  (s_tdata[AVG_BITS-1:0]),
        .push        (push),
        .push_cmd    (push_cmd),
        .queue_full  (queue_full)
    );

    llhs_cmd_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_cmd(push_cmd),
        .full    (queue_full),
        .pop     (pop),
        .head_cmd(head_cmd),
        .empty   (queue_empty)
    );

    llhs_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .head_cmd   (head_cmd),
        .queue_empty(queue_empty),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .out_kind   (out_kind),
        .out_value  (out_value),
        .out_verdict(out_verdict),
        .m_tlast    (m_tlast)
    );

    assign m_tdata = {4'b0000, out_verdict, out_value};
    assign m_tuser = out_kind;

endmodule

>>> hdl/llhs_cmd_queue.sv
// small command queue between the front and back parts
module llhs_cmd_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  llhs_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output llhs_pkg::cmd_t head_cmd,
    output logic           empty
);
    import llhs_pkg::*;

    cmd_t                 entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg, count_next;

    assign full     = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) count_next = count_reg + 1'b1;
        else if (pop && !push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

>>> hdl/llhs_front.sv
// front part: accepts items, runs the search state and issues commands
module llhs_front #(
    parameter int SEQUENCE_SLOTS = llhs_pkg::DEFAULT_SEQUENCE_SLOTS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  llhs_pkg::cfg_t                cfg,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic                          in_operation,
    input  logic [llhs_pkg::AVG_BITS-1:0] in_average,
    output logic                          push,
    output llhs_pkg::cmd_t                push_cmd,
    input  logic                          queue_full
);
    import llhs_pkg::*;

    localparam int SLOT_BITS = (SEQUENCE_SLOTS > 1) ? $clog2(SEQUENCE_SLOTS) : 1;
    localparam int USED_BITS = $clog2(SEQUENCE_SLOTS + 1);

    logic                  active_reg, active_next;
    logic [SLOT_BITS-1:0]  slot_reg, slot_next;
    logic [CODE_BITS-1:0]  channel_reg, channel_next;
    logic [DRIVE_BITS-1:0] drive_now_reg, drive_now_next;
    logic [DRIVE_BITS-1:0] drive_before_reg, drive_before_next;
    logic [ERR_BITS-1:0]   best_error_reg, best_error_next;
    logic [DRIVE_BITS-1:0] best_drive_reg, best_drive_next;

    logic                  accept;
    logic [USED_BITS-1:0]  used;
    logic [USED_BITS-1:0]  slot_plus;
    logic [CHANNELS-1:0]   mask;
    logic [CODE_BITS-1:0]  code;
    logic [CODE_BITS-1:0]  first_ch;
    logic [CODE_BITS-1:0]  following_ch;
    logic [AVG_BITS-1:0]   tgt;
    logic [AVG_BITS-1:0]   err16;
    logic [ERR_BITS-1:0]   err;
    logic [ERR_BITS-1:0]   tol;
    logic [ERR_BITS-1:0]   new_best_err;
    logic [DRIVE_BITS-1:0] new_best_drive;
    logic [DRIVE_BITS-1:0] step;
    logic [DRIVE_BITS:0]   raised;
    logic [DRIVE_BITS:0]   candidate;
    logic [DRIVE_BITS-1:0] ch_max;
    logic [DRIVE_BITS-1:0] next_drive;

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;

    // used slots saturate at the sequence depth
    assign used = (int'(cfg.sequence_length) > SEQUENCE_SLOTS) ? USED_BITS'(SEQUENCE_SLOTS)
                                                                : USED_BITS'(cfg.sequence_length);

    always_comb begin
        mask = '0;
        for (int i = 0; i < SEQUENCE_SLOTS; i++) begin
            code = slot_code(cfg.color_sequence, i);
            if ((i < int'(used)) && (code != CODE_KEEP)) begin
                mask = mask | (CHANNELS'(1) << code);
            end
        end
    end

    assign first_ch = (cfg.color_sequence[CODE_BITS-1:0] == CODE_KEEP)
                      ? '0 : cfg.color_sequence[CODE_BITS-1:0];

    // measurement arithmetic on the current channel
    assign tgt    = AVG_BITS'({channel_level(cfg.target, channel_reg), FRAC_BITS'(0)});
    assign err16  = (tgt > in_average) ? tgt - in_average : in_average - tgt;
    assign err    = ERR_BITS'(err16);
    assign tol    = ERR_BITS'({channel_level(cfg.tolerance, channel_reg), FRAC_BITS'(0)});
    assign ch_max = channel_drive(cfg.max_drive, channel_reg);
    assign step   = ((drive_now_reg > drive_before_reg) ? drive_now_reg - drive_before_reg
                                                        : drive_before_reg - drive_now_reg) >> 1;
    assign raised = {1'b0, drive_now_reg} + {1'b0, step};

    always_comb begin
        if (tgt < in_average) begin
            candidate = (step > drive_now_reg) ? '0 : {1'b0, drive_now_reg - step};
        end else if (tgt > in_average) begin
            candidate = raised;
        end else begin
            candidate = {1'b0, drive_now_reg};
        end
    end

    assign next_drive = (candidate > {1'b0, ch_max}) ? ch_max : candidate[DRIVE_BITS-1:0];

    assign new_best_err   = (err < best_error_reg) ? err : best_error_reg;
    assign new_best_drive = (err < best_error_reg) ? drive_now_reg : best_drive_reg;

    assign slot_plus    = USED_BITS'(slot_reg) + USED_BITS'(1);
    assign following_ch = (slot_code(cfg.color_sequence, int'(slot_plus)) == CODE_KEEP)
                          ? channel_reg : slot_code(cfg.color_sequence, int'(slot_plus));

    always_comb begin
        active_next       = active_reg;
        slot_next         = slot_reg;
        channel_next      = channel_reg;
        drive_now_next    = drive_now_reg;
        drive_before_next = drive_before_reg;
        best_error_next   = best_error_reg;
        best_drive_next   = best_drive_reg;
        push              = 1'b0;
        push_cmd          = '0;
        if (accept && (in_operation == OP_START)) begin
            push = 1'b1;
            if (mask == '0) begin
                active_next = 1'b0;
                push_cmd.op = CMD_EMPTY;
            end else begin
                active_next       = 1'b1;
                slot_next         = '0;
                channel_next      = first_ch;
                drive_now_next    = channel_drive(cfg.max_drive, first_ch);
                drive_before_next = '0;
                best_error_next   = '1;
                best_drive_next   = '0;
                push_cmd.op       = CMD_START;
                push_cmd.mask     = mask;
                push_cmd.channel  = first_ch;
                push_cmd.drive    = channel_drive(cfg.max_drive, first_ch);
            end
        end else if (accept && active_reg) begin
            push              = 1'b1;
            best_error_next   = new_best_err;
            best_drive_next   = new_best_drive;
            drive_before_next = drive_now_reg;
            if (next_drive != drive_now_reg) begin
                drive_now_next = next_drive;
                push_cmd.op    = CMD_DRIVE;
                push_cmd.drive = next_drive;
            end else begin
                push_cmd.best = new_best_drive;
                if (new_best_err > tol) begin
                    active_next = 1'b0;
                    push_cmd.op = CMD_FAIL;
                end else if (slot_plus < used) begin
                    // move on to the next slot of the sequence
                    slot_next         = SLOT_BITS'(slot_plus);
                    channel_next      = following_ch;
                    drive_now_next    = channel_drive(cfg.max_drive, following_ch);
                    drive_before_next = '0;
                    best_error_next   = '1;
                    best_drive_next   = '0;
                    push_cmd.op       = CMD_NEXT;
                    push_cmd.channel  = following_ch;
                    push_cmd.drive    = channel_drive(cfg.max_drive, following_ch);
                end else begin
                    active_next = 1'b0;
                    push_cmd.op = CMD_PASS;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg       <= 1'b0;
            slot_reg         <= '0;
            channel_reg      <= '0;
            drive_now_reg    <= '0;
            drive_before_reg <= '0;
            best_error_reg   <= '1;
            best_drive_reg   <= '0;
        end else begin
            active_reg       <= active_next;
            slot_reg         <= slot_next;
            channel_reg      <= channel_next;
            drive_now_reg    <= drive_now_next;
            drive_before_reg <= drive_before_next;
            best_error_reg   <= best_error_next;
            best_drive_reg   <= best_drive_next;
        end
    end

endmodule

>>> hdl/llhs_back.sv
// back part: expands each command into its run of result transfers
`include "light_level_halving_search_assert.svh"

module llhs_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  llhs_pkg::cfg_t                    cfg,
    input  llhs_pkg::cmd_t                    head_cmd,
    input  logic                              queue_empty,
    output logic                              pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [llhs_pkg::KIND_BITS-1:0]    out_kind,
    output logic [llhs_pkg::VALUE_BITS-1:0]   out_value,
    output logic [llhs_pkg::VERDICT_BITS-1:0] out_verdict,
    output logic                              m_tlast
);
    import llhs_pkg::*;

    localparam logic [2:0] B_IDLE     = 3'd0;
    localparam logic [2:0] B_MASK     = 3'd1;
    localparam logic [2:0] B_INIT_SEL = 3'd2;
    localparam logic [2:0] B_INIT_DRV = 3'd3;
    localparam logic [2:0] B_SEL      = 3'd4;
    localparam logic [2:0] B_DRV      = 3'd5;
    localparam logic [2:0] B_BEST     = 3'd6;
    localparam logic [2:0] B_VERDICT  = 3'd7;

    logic [2:0]           state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [CODE_BITS-1:0] init_ch_reg, init_ch_next;

    logic                 advance;
    logic                 found;
    logic [CODE_BITS-1:0] found_ch;
    logic [2:0]           load_state;
    int                   scan_from;

    assign m_tvalid = (state_reg != B_IDLE);
    assign m_tlast  = (state_reg == B_DRV) || (state_reg == B_VERDICT);
    assign advance  = (state_reg == B_IDLE) || (m_tvalid && m_tready);

    // lowest enabled channel at or above the scan start
    always_comb begin
        scan_from = (state_reg == B_MASK) ? 0 : int'(init_ch_reg) + 1;
        found     = 1'b0;
        found_ch  = '0;
        for (int c = CHANNELS - 1; c >= 0; c--) begin
            if (cmd_reg.mask[c] && (c >= scan_from)) begin
                found    = 1'b1;
                found_ch = CODE_BITS'(c);
            end
        end
    end

    always_comb begin
        unique case (head_cmd.op) inside
            CMD_START:                     load_state = B_MASK;
            CMD_DRIVE:                     load_state = B_DRV;
            CMD_FAIL, CMD_NEXT, CMD_PASS:  load_state = B_BEST;
            default:                       load_state = B_VERDICT;
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        init_ch_next = init_ch_reg;
        pop          = 1'b0;
        if (advance) begin
            if ((state_reg == B_IDLE) || m_tlast) begin
                if (!queue_empty) begin
                    pop        = 1'b1;
                    cmd_next   = head_cmd;
                    state_next = load_state;
                end else begin
                    state_next = B_IDLE;
                end
            end else begin
                unique case (state_reg)
                    B_MASK: begin
                        init_ch_next = found_ch;
                        state_next   = B_INIT_SEL;
                    end
                    B_INIT_SEL: state_next = B_INIT_DRV;
                    B_INIT_DRV: begin
                        if (found) begin
                            init_ch_next = found_ch;
                            state_next   = B_INIT_SEL;
                        end else begin
                            state_next = B_SEL;
                        end
                    end
                    B_SEL:  state_next = B_DRV;
                    B_BEST: state_next = (cmd_reg.op == CMD_NEXT) ? B_SEL : B_VERDICT;
                    default: state_next = B_IDLE;
                endcase
            end
        end
    end

    always_comb begin
        out_kind    = KIND_DRIVE;
        out_value   = '0;
        out_verdict = VERDICT_PASS;
        unique case (state_reg)
            B_MASK: begin
                out_kind  = KIND_MASK;
                out_value = VALUE_BITS'(cmd_reg.mask);
            end
            B_INIT_SEL: begin
                out_kind  = KIND_SELECT;
                out_value = VALUE_BITS'(SELECT_BASE - init_ch_reg);
            end
            B_INIT_DRV: out_value = VALUE_BITS'(channel_drive(cfg.initial_drive, init_ch_reg));
            B_SEL: begin
                out_kind  = KIND_SELECT;
                out_value = VALUE_BITS'(SELECT_BASE - cmd_reg.channel);
            end
            B_DRV:  out_value = VALUE_BITS'(cmd_reg.drive);
            B_BEST: out_value = VALUE_BITS'(cmd_reg.best);
            B_VERDICT: begin
                out_kind = KIND_VERDICT;
                case (cmd_reg.op)
                    CMD_EMPTY: out_verdict = VERDICT_NO_CHANNEL;
                    CMD_FAIL:  out_verdict = VERDICT_TOLERANCE;
                    default:   out_verdict = VERDICT_PASS;
                endcase
            end
            default: out_kind = KIND_DRIVE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        init_ch_reg <= init_ch_next;
    end

    `LLHS_ASSERT_ALWAYS(a_sel_only_for_new_channel, aclk, aresetn,
        (state_reg != B_SEL) || (cmd_reg.op == CMD_START) || (cmd_reg.op == CMD_NEXT),
        "channel select outside a start or next-channel command")

    `LLHS_ASSERT_ALWAYS(a_init_channel_enabled, aclk, aresetn,
        (state_reg != B_INIT_SEL) || (|(cmd_reg.mask & (CHANNELS'(1) << init_ch_reg))),
        "initial drive sent for a channel outside the mask")

    `LLHS_ASSERT_NEXT(a_idle_after_drain, aclk, aresetn,
        m_tvalid && m_tready && m_tlast && queue_empty, state_reg == B_IDLE,
        "back part busy after last transfer with an empty queue")

endmodule
